@@ rtl/drw_pkg.sv @@
`timescale 1ns / 1ps
package drw_pkg;

	// Opcodes of an input item
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_SWAP = 2'd1,
		OP_READ = 2'd2
	} opcode_t;

	// Result codes
	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_SWAPPED = 3'd1,
		ST_SHARED  = 3'd2,
		ST_EXISTS  = 3'd3,
		ST_BAD     = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [5:0]         node_src;
		logic [5:0]         node_dst;
		logic signed [31:0] edge_weight;
		logic [9:0]         edge_first;
		logic [9:0]         edge_second;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] read_weight;
		logic [10:0]        edges_loaded;
	} rsp_t;

	// Jump conditions of a control word; a true condition ends the item
	typedef enum logic [2:0] {
		CND_NONE     = 3'd0,
		CND_ALWAYS   = 3'd1,
		CND_LOAD_BAD = 3'd2,
		CND_READ_BAD = 3'd3,
		CND_IDX_BAD  = 3'd4,
		CND_SHARED   = 3'd5,
		CND_OCCUPIED = 3'd6
	} cond_t;

	// Weight store read address select
	typedef enum logic [2:0] {
		WA_REQ = 3'd0,
		WA_AD  = 3'd1,
		WA_CB  = 3'd2,
		WA_AB  = 3'd3,
		WA_CD  = 3'd4
	} wa_t;

	// Weight store write select
	typedef enum logic [2:0] {
		WW_NONE = 3'd0,
		WW_REQ  = 3'd1,
		WW_AD   = 3'd2,
		WW_AB   = 3'd3,
		WW_CB   = 3'd4,
		WW_CD   = 3'd5
	} ww_t;

	// Edge list write select
	typedef enum logic [1:0] {
		EW_NONE   = 2'd0,
		EW_LOAD   = 2'd1,
		EW_FIRST  = 2'd2,
		EW_SECOND = 2'd3
	} ew_t;

	// Datapath register load select
	typedef enum logic [2:0] {
		LD_NONE = 3'd0,
		LD_ABCD = 3'd1,
		LD_OCC  = 3'd2,
		LD_WAB  = 3'd3,
		LD_WCD  = 3'd4,
		LD_RD   = 3'd5
	} ld_t;

	typedef struct packed {
		logic    take;
		logic    emit;
		cond_t   cond;
		status_t st;
		wa_t     wa;
		ww_t     ww;
		ew_t     ew;
		ld_t     ld;
		logic    inc;
	} ctrl_t;

	typedef struct packed {
		logic load_bad;
		logic read_bad;
		logic idx_bad;
		logic shared;
		logic occupied;
	} flags_t;

endpackage

@@ rtl/directed_edge_swap_rewirer.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | req_t: opcode, nodes, weight, edge pair
// rsp     | out       | rsp_valid, rsp_stall | rsp_t: status, read weight, edge count
//
// A swap is the longest item; a swap that fails a check, a rejected load or read and
// an unknown opcode end early. The weight store is used for one access a cycle and
// sets the length of a swap: two cells are checked, two fetched and four written.
// Reset clears the edge count and starts a sweep that zeroes the weight store,
// one cell a cycle over all 2**(2*ceil(log2(MAX_NODES))) cells (4096 at 64 nodes);
// req_stall stays high until it ends. A result waits in the output register
// while the next item is accepted and worked on.
module directed_edge_swap_rewirer import drw_pkg::*; #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int AW = 2 * NW;
	localparam int DW = 2 * NW;
	localparam logic [31:0] NODE_LIM = 32'(MAX_NODES);

	ctrl_t  ctrl;
	flags_t flags;
	logic   taken;
	logic   accept;
	logic   clearing;
	logic   out_room;
	logic   emit;

	// Item registers
	logic [5:0]         src_q;
	logic [5:0]         dst_q;
	logic signed [31:0] wgt_q;
	logic [9:0]         e1_q;
	logic [9:0]         e2_q;

	// Working registers
	logic [CW-1:0]      count_q;
	logic [NW-1:0]      a_q, b_q, c_q, d_q;
	logic               occ_q;
	logic [31:0]        wab_q;
	logic [31:0]        wcd_q;
	logic signed [31:0] rd_q;
	status_t            status_q;

	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [NW-1:0] src_n, dst_n;
	logic          nodes_ok;

	// Memory ports
	logic          cell_we;
	logic [AW-1:0] cell_waddr;
	logic [31:0]   cell_wdata;
	logic [AW-1:0] cell_raddr;
	logic [31:0]   cell_rd_q;
	logic          edge_we;
	logic [EW-1:0] edge_waddr;
	logic [DW-1:0] edge_wdata;
	logic [DW-1:0] edge_a_q;
	logic [DW-1:0] edge_b_q;

	// Handshakes
	assign req_stall = !ctrl.take || clearing;
	assign accept    = req_valid && !req_stall;
	assign out_room  = !rsp_valid_q || !rsp_stall;
	assign emit      = ctrl.emit && out_room;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	drw_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (req.opcode),
		.flags    (flags),
		.out_room (out_room),
		.ctrl     (ctrl),
		.taken    (taken)
	);

	// Checks the microprogram jumps on
	assign src_n    = NW'(src_q);
	assign dst_n    = NW'(dst_q);
	assign nodes_ok = (32'(src_q) < NODE_LIM) && (32'(dst_q) < NODE_LIM);

	always_comb begin
		flags.read_bad = !nodes_ok;
		flags.load_bad = !nodes_ok || (wgt_q == '0) || (count_q == CW'(MAX_EDGES));
		flags.idx_bad  = (32'(e1_q) >= 32'(count_q)) || (32'(e2_q) >= 32'(count_q))
			|| (e1_q == e2_q);
		flags.shared   = (a_q == c_q) || (a_q == d_q) || (b_q == c_q) || (b_q == d_q);
		flags.occupied = occ_q;
	end

	// Weight store address and data selection; a cell is {source, destination}
	always_comb begin
		case (ctrl.wa)
			WA_AD:   cell_raddr = {a_q, d_q};
			WA_CB:   cell_raddr = {c_q, b_q};
			WA_AB:   cell_raddr = {a_q, b_q};
			WA_CD:   cell_raddr = {c_q, d_q};
			default: cell_raddr = {src_n, dst_n};
		endcase
	end

	always_comb begin
		cell_waddr = {src_n, dst_n};
		cell_wdata = wgt_q;
		case (ctrl.ww)
			WW_AD: begin
				cell_waddr = {a_q, d_q};
				cell_wdata = wab_q;
			end
			WW_AB: begin
				cell_waddr = {a_q, b_q};
				cell_wdata = '0;
			end
			WW_CB: begin
				cell_waddr = {c_q, b_q};
				cell_wdata = wcd_q;
			end
			WW_CD: begin
				cell_waddr = {c_q, d_q};
				cell_wdata = '0;
			end
			default: ;
		endcase
	end

	// Drop writes of a step whose check fails
	assign cell_we = (ctrl.ww != WW_NONE) && !taken;

	always_comb begin
		edge_waddr = count_q[EW-1:0];
		edge_wdata = {src_n, dst_n};
		case (ctrl.ew)
			EW_FIRST: begin
				edge_waddr = EW'(e1_q);
				edge_wdata = {a_q, d_q};
			end
			EW_SECOND: begin
				edge_waddr = EW'(e2_q);
				edge_wdata = {c_q, b_q};
			end
			default: ;
		endcase
	end

	assign edge_we = (ctrl.ew != EW_NONE) && !taken;

	drw_cells #(
		.AW (AW)
	) u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (cell_we),
		.waddr    (cell_waddr),
		.wdata    (cell_wdata),
		.raddr    (cell_raddr),
		.rdata_q  (cell_rd_q),
		.clearing (clearing)
	);

	drw_edges #(
		.DEPTH (MAX_EDGES),
		.EW    (EW),
		.DW    (DW)
	) u_edges (
		.clk       (clk),
		.we        (edge_we),
		.waddr     (edge_waddr),
		.wdata     (edge_wdata),
		.raddr_a   (EW'(e1_q)),
		.raddr_b   (EW'(e2_q)),
		.rdata_a_q (edge_a_q),
		.rdata_b_q (edge_b_q)
	);

	// Edge count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.inc && !taken) begin
			count_q <= CW'(count_q + 1'b1);
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			src_q <= req.node_src;
			dst_q <= req.node_dst;
			wgt_q <= req.edge_weight;
			e1_q  <= req.edge_first;
			e2_q  <= req.edge_second;
			rd_q  <= '0;
			occ_q <= 1'b0;
		end
		case (ctrl.ld)
			LD_ABCD: begin
				a_q <= edge_a_q[DW-1:NW];
				b_q <= edge_a_q[NW-1:0];
				c_q <= edge_b_q[DW-1:NW];
				d_q <= edge_b_q[NW-1:0];
			end
			LD_OCC:  occ_q <= occ_q || (cell_rd_q != '0);
			LD_WAB:  wab_q <= cell_rd_q;
			LD_WCD:  wcd_q <= cell_rd_q;
			LD_RD:   rd_q  <= cell_rd_q;
			default: ;
		endcase
		if (taken) begin
			status_q <= ctrl.st;
		end
	end

	// Output register: hold a result until taken, then advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.status       <= status_q;
			rsp_q.read_weight  <= rd_q;
			rsp_q.edges_loaded <= 11'(count_q);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_EDGES))
		else $error("edge count beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cell_we && (ctrl.ww == WW_AD)) |-> (!occ_q && !flags.shared))
		else $error("swap rewrite without a clean check");

	assert property (@(posedge clk) disable iff (!arst_n)
		cell_we |-> !clearing)
		else $error("weight write during clearing sweep");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(emit))
		else $error("result shown without a finish step");

endmodule

@@ rtl/drw_seq.sv @@
`timescale 1ns / 1ps
module drw_seq import drw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [1:0] opcode,
	input  flags_t     flags,
	input  logic       out_room,
	output ctrl_t      ctrl,
	output logic       taken
);

	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE = 5'd0;
	localparam step_t STEP_LD0  = 5'd1;
	localparam step_t STEP_LD1  = 5'd2;
	localparam step_t STEP_RD0  = 5'd3;
	localparam step_t STEP_RD1  = 5'd4;
	localparam step_t STEP_SW0  = 5'd5;
	localparam step_t STEP_SW1  = 5'd6;
	localparam step_t STEP_SW2  = 5'd7;
	localparam step_t STEP_SW3  = 5'd8;
	localparam step_t STEP_SW4  = 5'd9;
	localparam step_t STEP_SW5  = 5'd10;
	localparam step_t STEP_SW6  = 5'd11;
	localparam step_t STEP_SW7  = 5'd12;
	localparam step_t STEP_SW8  = 5'd13;
	localparam step_t STEP_SW9  = 5'd14;
	localparam step_t STEP_SW10 = 5'd15;
	localparam step_t STEP_BAD  = 5'd16;
	localparam step_t STEP_FIN  = 5'd17;

	// Microprogram: memory writes and the count increment of a word are
	// dropped when its condition fires.
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = '0;
		unique case (s)
			STEP_IDLE: w.take = 1'b1;
			STEP_LD0: begin
				w.cond = CND_LOAD_BAD;
				w.st   = ST_BAD;
				w.ww   = WW_REQ;
				w.ew   = EW_LOAD;
				w.inc  = 1'b1;
			end
			STEP_LD1: begin
				w.cond = CND_ALWAYS;
				w.st   = ST_DONE;
			end
			STEP_RD0: begin
				w.cond = CND_READ_BAD;
				w.st   = ST_BAD;
				w.wa   = WA_REQ;
			end
			STEP_RD1: begin
				w.cond = CND_ALWAYS;
				w.st   = ST_DONE;
				w.ld   = LD_RD;
			end
			STEP_SW0: begin
				w.cond = CND_IDX_BAD;
				w.st   = ST_BAD;
			end
			STEP_SW1: w.ld = LD_ABCD;
			STEP_SW2: begin
				w.cond = CND_SHARED;
				w.st   = ST_SHARED;
				w.wa   = WA_AD;
			end
			STEP_SW3: begin
				w.wa = WA_CB;
				w.ld = LD_OCC;
			end
			STEP_SW4: begin
				w.wa = WA_AB;
				w.ld = LD_OCC;
			end
			STEP_SW5: begin
				w.cond = CND_OCCUPIED;
				w.st   = ST_EXISTS;
				w.wa   = WA_CD;
				w.ld   = LD_WAB;
			end
			STEP_SW6: begin
				w.ld = LD_WCD;
				w.ww = WW_AD;
				w.ew = EW_FIRST;
			end
			STEP_SW7: begin
				w.ww = WW_AB;
				w.ew = EW_SECOND;
			end
			STEP_SW8: w.ww = WW_CB;
			STEP_SW9: w.ww = WW_CD;
			STEP_SW10: begin
				w.cond = CND_ALWAYS;
				w.st   = ST_SWAPPED;
			end
			STEP_BAD: begin
				w.cond = CND_ALWAYS;
				w.st   = ST_BAD;
			end
			STEP_FIN: w.emit = 1'b1;
			default: begin
				w.cond = CND_ALWAYS;
				w.st   = ST_BAD;
			end
		endcase
		return w;
	endfunction

	function automatic step_t entry(input logic [1:0] op);
		step_t s;
		s = STEP_BAD;
		unique case (op)
			OP_LOAD: s = STEP_LD0;
			OP_SWAP: s = STEP_SW0;
			OP_READ: s = STEP_RD0;
			default: s = STEP_BAD;
		endcase
		return s;
	endfunction

	step_t step_q;

	assign ctrl = ucode(step_q);

	always_comb begin
		unique case (ctrl.cond)
			CND_NONE:     taken = 1'b0;
			CND_ALWAYS:   taken = 1'b1;
			CND_LOAD_BAD: taken = flags.load_bad;
			CND_READ_BAD: taken = flags.read_bad;
			CND_IDX_BAD:  taken = flags.idx_bad;
			CND_SHARED:   taken = flags.shared;
			CND_OCCUPIED: taken = flags.occupied;
			default:      taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else if (ctrl.take) begin
			if (accept) begin
				step_q <= entry(opcode);
			end
		end else if (ctrl.emit) begin
			if (out_room) begin
				step_q <= STEP_IDLE;
			end
		end else if (taken) begin
			step_q <= STEP_FIN;
		end else begin
			step_q <= STEP_W'(step_q + 1'b1);
		end
	end

endmodule

@@ rtl/drw_cells.sv @@
`timescale 1ns / 1ps
module drw_cells import drw_pkg::*; #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata_q,
	output logic          clearing
);

	localparam int DEPTH = 1 << AW;

	logic [31:0]   mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic          clr_busy_q;

	// Sweep every cell to zero once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= AW'(clr_addr_q + 1'b1);
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign clearing = clr_busy_q;

endmodule

@@ rtl/drw_edges.sv @@
`timescale 1ns / 1ps
module drw_edges import drw_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int EW    = 10,
	parameter int DW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [EW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [EW-1:0] raddr_a,
	input  logic [EW-1:0] raddr_b,
	output logic [DW-1:0] rdata_a_q,
	output logic [DW-1:0] rdata_b_q
);

	// Each entry holds {source, destination}
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

endmodule
